// ===== hdl/rqbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rqbl_pkg
// shared types and constants for the look-back byte ring queue
// ----------------------------------------------------------------------------
package rqbl_pkg;

	// physical slot count of the ring store
	localparam int SLOT_DEPTH = 256;
	localparam int ADDR_W     = $clog2(SLOT_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int CAP_W      = 8;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_PUSH_FULL  = 2'd1,
		ST_POP_EMPTY  = 2'd2,
		ST_PEEK_RANGE = 2'd3
	} status_t;

	// one access to the slot store
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} slot_acc_t;

	// result fields that travel beside the read data
	typedef struct packed {
		logic    rd_ok;
		logic    holds;
		status_t status;
	} rsp_meta_t;

	// queue occupancy, seen by the top level checks
	typedef struct packed {
		logic [CAP_W-1:0] count;
		logic [CAP_W-1:0] cap;
	} fill_info_t;

endpackage

// ===== hdl/rqbl_if.sv =====
// ----------------------------------------------------------------------------
// rqbl_if
// command and response channels of the look-back byte ring queue
// ----------------------------------------------------------------------------
interface rqbl_cmd_if
	import rqbl_pkg::*;
();
	logic                valid;
	logic                ready;
	mode_t               mode;
	logic [BYTE_W-1:0]   push_byte;
	logic [CAP_W-1:0]    lookback_offset;

	modport source (output valid, mode, push_byte, lookback_offset, input ready);
	modport sink   (input valid, mode, push_byte, lookback_offset, output ready);
endinterface

interface rqbl_rsp_if
	import rqbl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              holds_items;
	status_t           status;

	modport source (output valid, read_byte, holds_items, status, input ready);
	modport sink   (input valid, read_byte, holds_items, status, output ready);
endinterface

// ===== hdl/rqbl_slot_ram.sv =====
// ----------------------------------------------------------------------------
// rqbl_slot_ram
// byte slot store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rqbl_slot_ram
	import rqbl_pkg::*;
(
	input  logic              clk,
	input  slot_acc_t         acc,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [SLOT_DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (acc.wr_en) begin
			mem[acc.addr] <= acc.wdata;
		end
		if (acc.rd_en) begin
			rdata_q <= mem[acc.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/rqbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqbl_ctrl
// ring pointers, fill count and capacity; decodes one accepted command per cycle
// ----------------------------------------------------------------------------
module rqbl_ctrl
	import rqbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mode_t             mode,
	input  logic [BYTE_W-1:0] push_byte,
	input  logic [CAP_W-1:0]  lookback_offset,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	output slot_acc_t         acc,
	output rsp_meta_t         meta,
	output fill_info_t        fill
);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] oldest_q;
	logic [CAP_W-1:0] newest_q;
	logic [CAP_W-1:0] count_q;

	logic [CAP_W-1:0] cap_eff;
	logic [CAP_W:0]   push_sum;
	logic [CAP_W:0]   push_pos;
	logic [CAP_W:0]   pop_next;
	logic [CAP_W:0]   peek_diff;
	logic [CAP_W:0]   peek_idx;

	logic [CAP_W-1:0] oldest_d;
	logic [CAP_W-1:0] newest_d;
	logic [CAP_W-1:0] count_d;

	// zero acts as one, anything past the store acts as the store size
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if ({1'b0, cap_q} > (CAP_W+1)'(SLOT_DEPTH)) begin
			cap_eff = CAP_W'(SLOT_DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	// slot after the newest, wrapped at the capacity
	assign push_sum = {1'b0, oldest_q} + {1'b0, count_q};
	assign push_pos = (push_sum >= {1'b0, cap_eff}) ? push_sum - {1'b0, cap_eff} : push_sum;
	assign pop_next = ({1'b0, oldest_q} + (CAP_W+1)'(1) >= {1'b0, cap_eff}) ?
		'0 : {1'b0, oldest_q} + (CAP_W+1)'(1);
	assign peek_diff = {1'b0, newest_q} - {1'b0, lookback_offset};
	assign peek_idx  = (lookback_offset > newest_q) ? peek_diff + {1'b0, cap_eff} : peek_diff;

	always_comb begin
		oldest_d    = oldest_q;
		newest_d    = newest_q;
		count_d     = count_q;
		acc.wr_en   = 1'b0;
		acc.rd_en   = 1'b0;
		acc.addr    = '0;
		acc.wdata   = push_byte;
		meta.rd_ok  = 1'b0;
		meta.status = ST_OK;
		case (mode)
			MODE_PUSH: begin
				if (count_q < cap_eff) begin
					count_d   = count_q + CAP_W'(1);
					newest_d  = push_pos[CAP_W-1:0];
					acc.wr_en = accept;
					acc.addr  = push_pos[ADDR_W-1:0];
				end else begin
					meta.status = ST_PUSH_FULL;
				end
			end
			MODE_POP: begin
				if (count_q == '0) begin
					meta.status = ST_POP_EMPTY;
				end else begin
					oldest_d   = pop_next[CAP_W-1:0];
					count_d    = count_q - CAP_W'(1);
					acc.rd_en  = accept;
					acc.addr   = oldest_q[ADDR_W-1:0];
					meta.rd_ok = 1'b1;
				end
			end
			MODE_PEEK: begin
				if (lookback_offset >= count_q) begin
					meta.status = ST_PEEK_RANGE;
				end else begin
					acc.rd_en  = accept;
					acc.addr   = peek_idx[ADDR_W-1:0];
					meta.rd_ok = 1'b1;
				end
			end
			MODE_CLEAR: begin
				oldest_d = '0;
				newest_d = '0;
				count_d  = '0;
			end
			default: begin
				meta.status = ST_OK;
			end
		endcase
		meta.holds = (count_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			oldest_q <= '0;
			newest_q <= '0;
			count_q  <= '0;
		end else if (cfg_we) begin
			cap_q    <= cfg_wdata;
			oldest_q <= '0;
			newest_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			oldest_q <= oldest_d;
			newest_q <= newest_d;
			count_q  <= count_d;
		end
	end

	assign fill.count = count_q;
	assign fill.cap   = cap_eff;

endmodule

// ===== hdl/ring_queue_byte_lookback.sv =====
// ----------------------------------------------------------------------------
// ring_queue_byte_lookback
// circular byte queue with push, pop, peek back from newest and clear
// ----------------------------------------------------------------------------
//  channel  dir  payload                              beat taken when
//  cmd      in   mode, push_byte, lookback_offset     cmd.valid & cmd.ready
//  rsp      out  read_byte, holds_items, status       rsp.valid & rsp.ready
//  cfg      in   cfg_wdata (capacity_in_use)          cfg_we
//
//  one command beat per cycle unless rsp is stalled; its response is registered
//  in the slot read register, then in the output register
//  throughput set by the single port of the slot store: one access a cycle
//  reset: empty queue, capacity 255; slot contents stay undefined
//  a stalled rsp fills the output and then the read stage before cmd.ready drops
// ----------------------------------------------------------------------------
module ring_queue_byte_lookback
	import rqbl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	rqbl_cmd_if.sink         cmd,
	rqbl_rsp_if.source       rsp
);

	logic              cmd_take;
	logic              s1_move;
	slot_acc_t         acc;
	rsp_meta_t         meta;
	fill_info_t        fill;
	logic [BYTE_W-1:0] ram_rdata;

	// read stage: meta beside the registered ram data
	logic              valid_s1;
	rsp_meta_t         meta_s1;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	rsp_meta_t         out_meta_q;

	// read stage moves on when the output slot is free or being drained
	assign s1_move  = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || s1_move;
	assign cmd_take = cmd.valid && cmd.ready;

	// pointer update and slot access are decided in the cycle of the beat
	rqbl_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (cmd_take),
		.mode            (cmd.mode),
		.push_byte       (cmd.push_byte),
		.lookback_offset (cmd.lookback_offset),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.acc             (acc),
		.meta            (meta),
		.fill            (fill)
	);

	// read data only updates on a taken beat, so it holds while stalled
	rqbl_slot_ram u_ram (
		.clk   (clk),
		.acc   (acc),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			meta_s1 <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// flagged or non-reading commands give a zero byte
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q <= meta_s1.rd_ok ? ram_rdata : '0;
			out_meta_q <= meta_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_byte   = out_byte_q;
	assign rsp.holds_items = out_meta_q.holds;
	assign rsp.status      = out_meta_q.status;

	// fill count never passes the wrap point
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill.count <= fill.cap)
		else $error("fill count above capacity");

	// a dropped push only happens on a full, hence non-empty, queue
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_PUSH_FULL |-> rsp.holds_items)
		else $error("push dropped on a queue reported empty");

	// an empty pop leaves the queue empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_POP_EMPTY |-> !rsp.holds_items)
		else $error("empty pop reported items");

	// a taken beat always lands in the read stage
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> valid_s1)
		else $error("accepted beat lost before read stage");

	// a beat that needs a read never also writes the store
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc.wr_en && acc.rd_en))
		else $error("slot store read and write in one cycle");

endmodule
